// ===== rtl/osa_pkg.sv =====
// Shared types and constants for the OSA edit distance unit.
// Used by the channel interfaces, the row feeder, the cells and the top level.
`default_nettype none

package osa_pkg;

    localparam int MAX_LEN_DEF = 64;
    localparam int FUNC_W      = 2;
    localparam int CHAR_W      = 8;
    localparam int DIST_W      = 7;

    // command codes
    localparam logic [FUNC_W-1:0] FUNC_APPEND_A = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_APPEND_B = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_COMPUTE  = 2'd2;

    // Row token that travels along the cell chain, one cell per cycle.
    typedef struct packed {
        logic              valid;
        logic              has_prev;   // row index above one
        logic              last;       // final row of the first string
        logic [CHAR_W-1:0] a;          // character of this row
        logic [CHAR_W-1:0] a_prev;     // character of the row above
    } osa_flow_t;

endpackage

`default_nettype wire

// ===== rtl/osa_in_if.sv =====
// Command channel: valid/ready handshake carrying func and ch.
// Depends on osa_pkg for the field widths.
`default_nettype none

interface osa_in_if;
    logic                         valid;
    logic                         ready;
    logic [osa_pkg::FUNC_W-1:0]   func;
    logic [osa_pkg::CHAR_W-1:0]   ch;

    modport source (output valid, output func, output ch, input ready);
    modport sink   (input valid, input func, input ch, output ready);
endinterface

`default_nettype wire

// ===== rtl/osa_out_if.sv =====
// Result channel: valid/ready handshake carrying distance and too_long.
// Depends on osa_pkg for the field widths.
`default_nettype none

interface osa_out_if;
    logic                         valid;
    logic                         ready;
    logic [osa_pkg::DIST_W-1:0]   distance;
    logic                         too_long;

    modport source (output valid, output distance, output too_long, input ready);
    modport sink   (input valid, input distance, input too_long, output ready);
endinterface

`default_nettype wire

// ===== rtl/osa_row_feed.sv =====
// First-string store and row sequencer: issues one row token per cycle into the chain.
// Depends on osa_pkg.
`default_nettype none

module osa_row_feed #(
    parameter int MAX_LEN = osa_pkg::MAX_LEN_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           wr_en,
    input  wire logic [((MAX_LEN > 1) ? $clog2(MAX_LEN) : 1)-1:0] wr_addr,
    input  wire logic [osa_pkg::CHAR_W-1:0]     wr_data,
    input  wire logic                           start,
    input  wire logic [$clog2(MAX_LEN+1)-1:0]   len,
    output osa_pkg::osa_flow_t                  flow,
    output logic [$clog2(MAX_LEN+2)-1:0]        l_val,
    output logic [$clog2(MAX_LEN+2)-1:0]        ul_val
);

    localparam int AW   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int LenW = $clog2(MAX_LEN + 1);
    localparam int DW   = $clog2(MAX_LEN + 2);

    logic [osa_pkg::CHAR_W-1:0] mem [MAX_LEN];

    logic                       active_reg;
    logic [LenW-1:0]            cnt_reg;
    logic [LenW-1:0]            len_reg;
    logic                       valid_reg;
    logic                       last_reg;
    logic [LenW-1:0]            row_reg;
    logic [osa_pkg::CHAR_W-1:0] a_rd_reg;
    logic [osa_pkg::CHAR_W-1:0] a_prev_reg;
    logic [LenW-1:0]            cnt_next;

    assign cnt_next = cnt_reg + LenW'(1);

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (active_reg) begin
            a_rd_reg   <= mem[cnt_reg[AW-1:0]];
            a_prev_reg <= a_rd_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            active_reg <= 1'b0;
            cnt_reg    <= '0;
            len_reg    <= '0;
            valid_reg  <= 1'b0;
            last_reg   <= 1'b0;
            row_reg    <= '0;
        end else begin
            valid_reg <= active_reg;
            last_reg  <= active_reg && (cnt_next == len_reg);
            if (start) begin
                active_reg <= 1'b1;
                cnt_reg    <= '0;
                len_reg    <= len;
            end else if (active_reg) begin
                cnt_reg <= cnt_next;
                row_reg <= cnt_next;
                // stop after the last row is issued
                if (cnt_next == len_reg) begin
                    active_reg <= 1'b0;
                end
            end
        end
    end

    always_comb begin
        flow.valid    = valid_reg;
        flow.has_prev = (row_reg > LenW'(1));
        flow.last     = last_reg;
        flow.a        = a_rd_reg;
        flow.a_prev   = a_prev_reg;
        // column zero of the table: D[i][0] = i, D[i-1][0] = i-1
        l_val         = DW'(row_reg);
        ul_val        = DW'(row_reg - LenW'(1));
    end

endmodule

`default_nettype wire

// ===== rtl/osa_cell.sv =====
// One column cell of the systolic OSA array: holds b[j] and the last table value of column j.
// Depends on osa_pkg.
`default_nettype none

module osa_cell #(
    parameter int MAX_LEN = osa_pkg::MAX_LEN_DEF,
    parameter int COL     = 1
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           init,
    input  wire logic                           b_we,
    input  wire logic [osa_pkg::CHAR_W-1:0]     b_data,
    input  wire logic [osa_pkg::CHAR_W-1:0]     b_left,
    output logic [osa_pkg::CHAR_W-1:0]          b_own,
    input  wire osa_pkg::osa_flow_t             flow_in,
    input  wire logic [$clog2(MAX_LEN+2)-1:0]   l_in,
    input  wire logic [$clog2(MAX_LEN+2)-1:0]   ul_in,
    input  wire logic [$clog2(MAX_LEN+2)-1:0]   uul_in,
    output osa_pkg::osa_flow_t                  flow_out,
    output logic [$clog2(MAX_LEN+2)-1:0]        l_out,
    output logic [$clog2(MAX_LEN+2)-1:0]        ul_out,
    output logic [$clog2(MAX_LEN+2)-1:0]        uul_out
);

    localparam int  DW       = $clog2(MAX_LEN + 2);
    localparam bit  USE_XPOS = (COL > 1);

    logic [osa_pkg::CHAR_W-1:0] b_reg;
    logic [DW-1:0]              up_reg;       // D[i-1][j]
    logic [DW-1:0]              ul_seen_reg;  // last D[i-1][j-1] seen, forwarded one row later
    osa_pkg::osa_flow_t         flow_reg;
    logic [DW-1:0]              l_reg;
    logic [DW-1:0]              ul_reg;
    logic [DW-1:0]              uul_reg;

    logic [DW-1:0] c_up;
    logic [DW-1:0] c_left;
    logic [DW-1:0] c_diag;
    logic [DW-1:0] c_xpos;
    logic [DW-1:0] d_min;
    logic [DW-1:0] d_next;
    logic          xpos_hit;

    always_comb begin
        c_up     = up_reg + DW'(1);
        c_left   = l_in + DW'(1);
        c_diag   = ul_in + DW'(flow_in.a != b_reg);
        c_xpos   = uul_in + DW'(1);
        xpos_hit = USE_XPOS && flow_in.has_prev
                   && (flow_in.a == b_left) && (flow_in.a_prev == b_reg);
        d_min    = (c_up < c_left) ? c_up : c_left;
        d_min    = (c_diag < d_min) ? c_diag : d_min;
        d_next   = (xpos_hit && (c_xpos < d_min)) ? c_xpos : d_min;
    end

    always_ff @(posedge clk) begin
        if (b_we) begin
            b_reg <= b_data;
        end
        if (init) begin
            up_reg <= DW'(COL);
        end else if (flow_in.valid) begin
            up_reg <= d_next;
        end
        if (flow_in.valid) begin
            ul_seen_reg <= ul_in;
            l_reg       <= d_next;
            ul_reg      <= up_reg;
            uul_reg     <= ul_seen_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            flow_reg <= '0;
        end else begin
            flow_reg <= flow_in;
        end
    end

    assign b_own    = b_reg;
    assign flow_out = flow_reg;
    assign l_out    = l_reg;
    assign ul_out   = ul_reg;
    assign uul_out  = uul_reg;

endmodule

`default_nettype wire

// ===== rtl/osa_edit_distance_unit.sv =====
// Top level of the OSA edit distance unit: command decode, string lengths, cell chain, result.
// Depends on osa_pkg, osa_in_if, osa_out_if, osa_row_feed and osa_cell.
//
// Usage:
//   cmd carries one word per command. func APPEND_A appends ch to the first string,
//   APPEND_B to the second, COMPUTE emits the optimal string alignment distance on res
//   together with a flag that some character was dropped because a string was full
//   (MAX_LEN characters); func 3 is taken and ignored.
//   A compute with lengths n and m (both nonzero) streams the n characters of the first
//   string through a chain of MAX_LEN column cells, one row per cycle; each cell
//   evaluates one table entry per cycle on the anti-diagonal wavefront, and D[n][m]
//   is taken as the last row leaves column m. With either string empty the result
//   is the length of the other string and no row is streamed.
//   cmd.ready is high only while no compute is in progress.
//   The result sits in an output register; while res is stalled the block keeps
//   taking appends and a compute, whose result then waits until the held one is taken.
//   After a compute both strings and the flag are cleared.
//   Reset clears lengths, flag, control state and res.valid; the string stores need
//   no clearing since only written entries are read.
`default_nettype none

module osa_edit_distance_unit #(
    parameter int MAX_LEN = osa_pkg::MAX_LEN_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    osa_in_if.sink     cmd,
    osa_out_if.source  res
);

    localparam int AW   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int LenW = $clog2(MAX_LEN + 1);
    localparam int DW   = $clog2(MAX_LEN + 2);
    localparam int ExtW = (DW > osa_pkg::DIST_W) ? DW : osa_pkg::DIST_W;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    logic [1:0]      state_reg;
    logic [1:0]      state_next;
    logic [LenW-1:0] first_len_reg;
    logic [LenW-1:0] second_len_reg;
    logic            overflow_reg;
    logic [LenW-1:0] m_run_reg;
    logic            tl_run_reg;
    logic [DW-1:0]   dist_run_reg;
    logic            res_valid_reg;
    logic [osa_pkg::DIST_W-1:0] res_dist_reg;
    logic            res_tl_reg;

    logic            accept;
    logic            do_append_a;
    logic            do_append_b;
    logic            do_compute;
    logic            a_full;
    logic            b_full;
    logic            start;
    logic            hit;
    logic [DW-1:0]   hit_dist;
    logic            load_res;
    logic [ExtW-1:0] dist_ext;

    // chain wiring: index 0 is the feeder, index k the output of cell k
    osa_pkg::osa_flow_t          flow_w [MAX_LEN+1];
    logic [DW-1:0]               l_w    [MAX_LEN+1];
    logic [DW-1:0]               ul_w   [MAX_LEN+1];
    logic [DW-1:0]               uul_w  [MAX_LEN+1];
    logic [osa_pkg::CHAR_W-1:0]  b_w    [MAX_LEN+1];
    logic [MAX_LEN-1:0]          b_we;

    assign cmd.ready   = (state_reg == ST_IDLE);
    assign accept      = cmd.valid && cmd.ready;
    assign do_append_a = accept && (cmd.func == osa_pkg::FUNC_APPEND_A);
    assign do_append_b = accept && (cmd.func == osa_pkg::FUNC_APPEND_B);
    assign do_compute  = accept && (cmd.func == osa_pkg::FUNC_COMPUTE);
    assign a_full      = (first_len_reg == LenW'(MAX_LEN));
    assign b_full      = (second_len_reg == LenW'(MAX_LEN));
    assign start       = do_compute && (first_len_reg != '0) && (second_len_reg != '0);

    osa_row_feed #(
        .MAX_LEN (MAX_LEN)
    ) u_feed (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (do_append_a && !a_full),
        .wr_addr (first_len_reg[AW-1:0]),
        .wr_data (cmd.ch),
        .start   (start),
        .len     (first_len_reg),
        .flow    (flow_w[0]),
        .l_val   (l_w[0]),
        .ul_val  (ul_w[0])
    );

    assign uul_w[0] = '0;  // never used by the first column
    assign b_w[0]   = '0;

    genvar gk;
    generate
        for (gk = 0; gk < MAX_LEN; gk++) begin : g_col
            // write strobe for column gk+1 when it is the next free slot
            assign b_we[gk] = do_append_b && !b_full && (second_len_reg == LenW'(gk));

            osa_cell #(
                .MAX_LEN (MAX_LEN),
                .COL     (gk + 1)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .init     (start),
                .b_we     (b_we[gk]),
                .b_data   (cmd.ch),
                .b_left   (b_w[gk]),
                .b_own    (b_w[gk+1]),
                .flow_in  (flow_w[gk]),
                .l_in     (l_w[gk]),
                .ul_in    (ul_w[gk]),
                .uul_in   (uul_w[gk]),
                .flow_out (flow_w[gk+1]),
                .l_out    (l_w[gk+1]),
                .ul_out   (ul_w[gk+1]),
                .uul_out  (uul_w[gk+1])
            );
        end
    endgenerate

    // pick D[n][m] as the last row leaves column m
    always_comb begin
        hit      = 1'b0;
        hit_dist = '0;
        for (int k = 1; k <= MAX_LEN; k++) begin
            if (flow_w[k].valid && flow_w[k].last && (m_run_reg == LenW'(k))) begin
                hit      = 1'b1;
                hit_dist = hit_dist | l_w[k];
            end
        end
    end

    assign load_res = (state_reg == ST_DRAIN) && (!res_valid_reg || res.ready);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    state_next = ST_RUN;
                end else if (do_compute) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_RUN: begin
                if (hit) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (load_res) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg      <= ST_IDLE;
            first_len_reg  <= '0;
            second_len_reg <= '0;
            overflow_reg   <= 1'b0;
            res_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (do_append_a) begin
                if (a_full) begin
                    overflow_reg <= 1'b1;
                end else begin
                    first_len_reg <= first_len_reg + LenW'(1);
                end
            end
            if (do_append_b) begin
                if (b_full) begin
                    overflow_reg <= 1'b1;
                end else begin
                    second_len_reg <= second_len_reg + LenW'(1);
                end
            end
            // clear both strings once the compute word is taken
            if (do_compute) begin
                first_len_reg  <= '0;
                second_len_reg <= '0;
                overflow_reg   <= 1'b0;
            end
            if (load_res) begin
                res_valid_reg <= 1'b1;
            end else if (res.ready) begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    assign dist_ext = ExtW'(dist_run_reg);

    always_ff @(posedge clk) begin
        if (do_compute) begin
            m_run_reg  <= second_len_reg;
            tl_run_reg <= overflow_reg;
            // an empty string gives the length of the other one
            dist_run_reg <= (first_len_reg == '0) ? DW'(second_len_reg) : DW'(first_len_reg);
        end else if ((state_reg == ST_RUN) && hit) begin
            dist_run_reg <= hit_dist;
        end
        if (load_res) begin
            res_dist_reg <= dist_ext[osa_pkg::DIST_W-1:0];
            res_tl_reg   <= tl_run_reg;
        end
    end

    assign res.valid    = res_valid_reg;
    assign res.distance = res_dist_reg;
    assign res.too_long = res_tl_reg;

endmodule

`default_nettype wire

// ===== verif/osa_edit_distance_unit_tb.sv =====
`timescale 1ns / 100ps
// Testbench for osa_edit_distance_unit: drives append/compute words on cmd and checks res.
// Depends on osa_pkg, osa_in_if, osa_out_if and the unit itself; predicts each distance locally.

module osa_edit_distance_unit_tb;

    // Selector value that the unit takes and ignores.
    localparam logic [osa_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    localparam int STR_MAX      = osa_pkg::MAX_LEN_DEF;
    localparam int WORD_TARGET  = 1550;
    localparam int IDLE_PERCENT = 19;
    // Hang guard limit, set many times above the slowest correct run.
    localparam int CYCLE_LIMIT  = 1500000;
    // Drain time after the last result: one full table sweep plus margin.
    localparam int DRAIN_CYCLES = 2 * STR_MAX + 16;

    typedef struct packed {
        logic [osa_pkg::DIST_W-1:0] distance;
        logic                       too_long;
    } osa_result_t;

    logic clk;
    logic rst_n;

    osa_in_if  cmd_if ();
    osa_out_if res_if ();

    osa_edit_distance_unit i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .res   (res_if)
    );

    // Local copy of the unit's string state, updated on every accepted word.
    logic [osa_pkg::CHAR_W-1:0] first_chars  [STR_MAX];
    logic [osa_pkg::CHAR_W-1:0] second_chars [STR_MAX];
    int                first_count;
    int                second_count;
    logic              chars_dropped;

    osa_result_t       pending_distances [$];
    int                mismatch_count;
    int                words_sent;
    int                cycle_count;
    bit                no_idle;

    // Stimulus buffers for one string pair and the alphabet used to fill them.
    logic [osa_pkg::CHAR_W-1:0] pair_first  [$];
    logic [osa_pkg::CHAR_W-1:0] pair_second [$];
    int                alpha_base;
    bit                alpha_narrow;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Guard against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Result side back-pressure: stall at random IDLE_PERCENT of the time, except in the
    // steady stretch where both sides run flat out.
    always @(posedge clk)
    begin
        if (no_idle)
            res_if.ready <= 1'b1;
        else
            res_if.ready <= ($urandom_range(99) >= IDLE_PERCENT);
    end

    // Full optimal string alignment table over the loaded strings. Row 0 and
    // column 0 carry the pure insert/delete costs, which also covers the case
    // where either string is empty.
    function automatic logic [osa_pkg::DIST_W-1:0] predict_osa_distance();
        int cost_table [0:STR_MAX][0:STR_MAX];
        int i;
        int j;
        int sub_cost;
        int best;
        for (i = 0; i <= first_count; i++)
            cost_table[i][0] = i;
        for (j = 0; j <= second_count; j++)
            cost_table[0][j] = j;
        for (i = 1; i <= first_count; i++)
        begin
            for (j = 1; j <= second_count; j++)
            begin
                sub_cost = (first_chars[i-1] == second_chars[j-1]) ? 0 : 1;
                best = cost_table[i-1][j] + 1;
                if (cost_table[i][j-1] + 1 < best)
                    best = cost_table[i][j-1] + 1;
                if (cost_table[i-1][j-1] + sub_cost < best)
                    best = cost_table[i-1][j-1] + sub_cost;
                // adjacent swap: a[i-1]=b[j-2] and a[i-2]=b[j-1]
                if (i > 1 && j > 1 &&
                    first_chars[i-1] == second_chars[j-2] &&
                    first_chars[i-2] == second_chars[j-1] &&
                    cost_table[i-2][j-2] + 1 < best)
                    best = cost_table[i-2][j-2] + 1;
                cost_table[i][j] = best;
            end
        end
        return osa_pkg::DIST_W'(cost_table[first_count][second_count]);
    endfunction

    // Apply one accepted word to the local state; a compute queues its result.
    task automatic track_word(input logic [osa_pkg::FUNC_W-1:0] func,
                              input logic [osa_pkg::CHAR_W-1:0] ch);
        osa_result_t expected;
        case (func)
            osa_pkg::FUNC_APPEND_A:
            begin
                if (first_count < STR_MAX)
                begin
                    first_chars[first_count] = ch;
                    first_count++;
                end
                else
                    chars_dropped = 1'b1;
            end
            osa_pkg::FUNC_APPEND_B:
            begin
                if (second_count < STR_MAX)
                begin
                    second_chars[second_count] = ch;
                    second_count++;
                end
                else
                    chars_dropped = 1'b1;
            end
            osa_pkg::FUNC_COMPUTE:
            begin
                expected.distance = predict_osa_distance();
                expected.too_long = chars_dropped;
                pending_distances.push_back(expected);
                first_count   = 0;
                second_count  = 0;
                chars_dropped = 1'b0;
            end
            default:
            begin
                // unused selector: nothing changes
            end
        endcase
    endtask

    // Send one word: idle at random first, then hold valid until ready is seen
    // at a rising edge. Valid is only lowered while idling, so a back-to-back
    // word never sees a low and a high in the same step.
    task automatic send_word(input logic [osa_pkg::FUNC_W-1:0] func,
                             input logic [osa_pkg::CHAR_W-1:0] ch);
        while (!no_idle && $urandom_range(99) < IDLE_PERCENT)
        begin
            cmd_if.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_if.valid <= 1'b1;
        cmd_if.func  <= func;
        cmd_if.ch    <= ch;
        do
            @(posedge clk);
        while (!cmd_if.ready);
        track_word(func, ch);
        if (func != FUNC_UNUSED)
            words_sent++;
    endtask

    // Check every accepted result against the oldest prediction.
    always @(posedge clk)
    begin
        osa_result_t expected;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (pending_distances.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected result: expected none, actual %0d too_long %0b",
                         $time, res_if.distance, res_if.too_long);
            end
            else
            begin
                expected = pending_distances.pop_front();
                if (res_if.distance !== expected.distance)
                begin
                    mismatch_count++;
                    $display("%0t: distance: expected %0d, actual %0d",
                             $time, expected.distance, res_if.distance);
                end
                if (res_if.too_long !== expected.too_long)
                begin
                    mismatch_count++;
                    $display("%0t: too_long: expected %0b, actual %0b",
                             $time, expected.too_long, res_if.too_long);
                end
            end
        end
    end

    function automatic logic [osa_pkg::CHAR_W-1:0] pick_char();
        if (alpha_narrow)
            return osa_pkg::CHAR_W'(alpha_base + $urandom_range(3));
        return osa_pkg::CHAR_W'($urandom_range(255));
    endfunction

    // Mostly short strings to keep sweeps short, a few near full, a few past full.
    function automatic int pick_length();
        int roll;
        roll = $urandom_range(99);
        if (roll < 65)
            return $urandom_range(8);
        if (roll < 88)
            return $urandom_range(30, 9);
        if (roll < 97)
            return $urandom_range(STR_MAX, 31);
        return $urandom_range(STR_MAX + 6, STR_MAX + 1);
    endfunction

    function automatic void fill_first(input int len);
        pair_first.delete();
        repeat (len)
            pair_first.push_back(pick_char());
    endfunction

    function automatic void fill_second(input int len);
        pair_second.delete();
        repeat (len)
            pair_second.push_back(pick_char());
    endfunction

    // Derive the second string from the first with a few edits, so the
    // distance stays small and swaps of neighbors actually occur.
    function automatic void derive_second();
        int edits;
        int pos;
        logic [osa_pkg::CHAR_W-1:0] held;
        pair_second = pair_first;
        edits = $urandom_range(4, 1);
        repeat (edits)
        begin
            case ($urandom_range(3))
                0:
                begin
                    if (pair_second.size() > 0)
                        pair_second[$urandom_range(pair_second.size() - 1)] = pick_char();
                end
                1:
                begin
                    pos = $urandom_range(pair_second.size());
                    pair_second.insert(pos, pick_char());
                end
                2:
                begin
                    if (pair_second.size() > 0)
                        pair_second.delete($urandom_range(pair_second.size() - 1));
                end
                default:
                begin
                    if (pair_second.size() > 1)
                    begin
                        pos = $urandom_range(pair_second.size() - 2);
                        held = pair_second[pos];
                        pair_second[pos] = pair_second[pos+1];
                        pair_second[pos+1] = held;
                    end
                end
            endcase
        end
    endfunction

    // Load the pair with the two strings interleaved at random, sprinkle in
    // the odd ignored word, then ask for the distance.
    task automatic load_and_compute();
        int ia;
        int ib;
        ia = 0;
        ib = 0;
        while (ia < pair_first.size() || ib < pair_second.size())
        begin
            if ($urandom_range(99) < 3)
                send_word(FUNC_UNUSED, osa_pkg::CHAR_W'($urandom_range(255)));
            if (ib >= pair_second.size() || (ia < pair_first.size() && $urandom_range(1) == 1))
            begin
                send_word(osa_pkg::FUNC_APPEND_A, pair_first[ia]);
                ia++;
            end
            else
            begin
                send_word(osa_pkg::FUNC_APPEND_B, pair_second[ib]);
                ib++;
            end
        end
        send_word(osa_pkg::FUNC_COMPUTE, osa_pkg::CHAR_W'($urandom_range(255)));
    endtask

    // Empty strings: both empty, only the first, only the second.
    task automatic test_empty_strings();
        send_word(osa_pkg::FUNC_COMPUTE, 8'h00);
        send_word(osa_pkg::FUNC_APPEND_A, 8'h78);
        send_word(osa_pkg::FUNC_COMPUTE, 8'hFF);
        send_word(osa_pkg::FUNC_APPEND_B, 8'hFF);
        send_word(osa_pkg::FUNC_APPEND_B, 8'h00);
        send_word(osa_pkg::FUNC_COMPUTE, 8'h5A);
    endtask

    // Swap of neighbors at the byte extremes, a case where the restricted
    // alignment costs more than true edit distance, and equal strings.
    task automatic test_edit_kinds();
        send_word(osa_pkg::FUNC_APPEND_A, 8'h00);
        send_word(osa_pkg::FUNC_APPEND_A, 8'hFF);
        send_word(osa_pkg::FUNC_APPEND_B, 8'hFF);
        send_word(osa_pkg::FUNC_APPEND_B, 8'h00);
        send_word(osa_pkg::FUNC_COMPUTE, 8'hA5);
        send_word(osa_pkg::FUNC_APPEND_A, "c");
        send_word(osa_pkg::FUNC_APPEND_A, "a");
        send_word(osa_pkg::FUNC_APPEND_B, "a");
        send_word(osa_pkg::FUNC_APPEND_B, "b");
        send_word(osa_pkg::FUNC_APPEND_B, "c");
        send_word(osa_pkg::FUNC_COMPUTE, 8'h00);
        send_word(osa_pkg::FUNC_APPEND_A, 8'h55);
        send_word(osa_pkg::FUNC_APPEND_B, 8'h55);
        send_word(osa_pkg::FUNC_COMPUTE, 8'hFF);
    endtask

    // Unused selectors around an append must leave the strings alone.
    task automatic test_unused_func();
        send_word(FUNC_UNUSED, 8'hAA);
        send_word(osa_pkg::FUNC_APPEND_A, "q");
        send_word(FUNC_UNUSED, 8'h55);
        send_word(osa_pkg::FUNC_COMPUTE, 8'h3C);
    endtask

    // Full strings: overflow each side in turn, then an overflowing first string with a derived second.
    task automatic test_full_strings();
        alpha_narrow = 1'b0;
        fill_first(STR_MAX + 2);
        fill_second(5);
        load_and_compute();
        fill_first(3);
        fill_second(STR_MAX + 1);
        load_and_compute();
        alpha_narrow = 1'b1;
        alpha_base   = $urandom_range(252);
        fill_first(STR_MAX + 1);
        derive_second();
        load_and_compute();
    endtask

    // Random pairs until the word budget is spent. Most second strings are a
    // few edits away from the first, the rest independent; a middle stretch
    // runs with no idling on either side.
    task automatic test_random_pairs();
        while (words_sent < WORD_TARGET)
        begin
            no_idle      = (words_sent >= 700 && words_sent < 1000);
            alpha_narrow = ($urandom_range(1) == 1);
            alpha_base   = $urandom_range(252);
            fill_first(pick_length());
            if ($urandom_range(99) < 60)
                derive_second();
            else
                fill_second(pick_length());
            load_and_compute();
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        cmd_if.valid   = 1'b0;
        cmd_if.func    = osa_pkg::FUNC_APPEND_A;
        cmd_if.ch      = '0;
        res_if.ready   = 1'b0;
        first_count    = 0;
        second_count   = 0;
        chars_dropped  = 1'b0;
        mismatch_count = 0;
        words_sent     = 0;
        cycle_count    = 0;
        no_idle        = 1'b0;
        alpha_base     = 0;
        alpha_narrow   = 1'b0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_strings();
        test_edit_kinds();
        test_unused_func();
        test_full_strings();
        test_random_pairs();

        cmd_if.valid <= 1'b0;
        // Drain outstanding results, then let any stray output show up.
        while (pending_distances.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
